// File: rtl/nat_address_translator_defines.svh
// ----------------------------------------------------------------------------
// NAT address translator assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef NAT_ADDRESS_TRANSLATOR_DEFINES_SVH
`define NAT_ADDRESS_TRANSLATOR_DEFINES_SVH

// clocked check, switched off while reset is asserted
`define NAT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define NAT_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/nat_pkg.sv
// ----------------------------------------------------------------------------
// NAT address translator package
// Types, codes and helpers shared by the translator and its checker.
// ----------------------------------------------------------------------------
package nat_pkg;

	localparam int POOL_DEPTH = 16;
	localparam int IDX_W      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
	localparam int CNT_W      = 5;
	localparam int CMP_W      = (IDX_W > CNT_W) ? IDX_W : CNT_W;
	localparam int ADDR_W     = 32;

	localparam logic       REG_POOL_BASE  = 1'b0;
	localparam logic       REG_POOL_COUNT = 1'b1;
	localparam logic [CNT_W-1:0] POOL_COUNT_RST = CNT_W'(16);

	typedef enum logic [2:0] {
		V_PASS    = 3'd0,
		V_XLAT    = 3'd1,
		V_BLOCK   = 3'd2,
		V_EXHAUST = 3'd3,
		V_MISS    = 3'd4
	} verdict_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_SRC,
		ST_SCAN_DST,
		ST_ALLOC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] src_addr;
		logic [ADDR_W-1:0] dst_addr;
	} in_t;

	typedef struct packed {
		logic [ADDR_W-1:0] new_src_addr;
		logic [ADDR_W-1:0] new_dst_addr;
		verdict_t          verdict;
	} out_t;

	// 10/8, 172.16/12, 192.168/16
	function automatic logic is_private(input logic [ADDR_W-1:0] a);
		return (a[31:24] == 8'h0A) || (a[31:20] == 12'hAC1) || (a[31:16] == 16'hC0A8);
	endfunction

endpackage

// File: rtl/nat_address_translator.sv
// ----------------------------------------------------------------------------
// NAT address translator
// Source NAT over a public address pool with a small translation table.
// ----------------------------------------------------------------------------
// Pass and block go straight to the output state; a table hit ends the scan at
// that entry; a new outbound flow walks the whole table, then allocates; an
// inbound miss walks the whole table. One transfer at a time: the single entry
// comparator walks the table one entry per cycle; a new packet waits until the
// last result is registered out. Reset clears all entry valid and pool busy
// flags at once, pool_base to 0 and pool_count to 16; address stores are not cleared.
module nat_address_translator (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  nat_pkg::in_t           in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output nat_pkg::out_t          out_data,
	input  logic                   cfg_we,
	input  logic                   cfg_idx,
	input  logic [31:0]            cfg_data
);
	import nat_pkg::*;

	state_t state_q, state_d;

	logic [IDX_W-1:0]      idx_q;
	logic                  slot_found_q, ent_found_q;
	logic [IDX_W-1:0]      slot_q, ent_q;
	logic [POOL_DEPTH-1:0] valid_q, busy_q;
	logic [ADDR_W-1:0]     priv_q [POOL_DEPTH];
	logic [ADDR_W-1:0]     pub_q  [POOL_DEPTH];
	logic [ADDR_W-1:0]     src_q, dst_q;
	logic [ADDR_W-1:0]     pool_base_q;
	logic [CNT_W-1:0]      pool_count_q;
	out_t                  res_q, out_q;
	logic                  out_valid_q;

	logic              sp, dp, last, hit, in_pool, out_free, can_alloc;
	logic [ADDR_W-1:0] cmp_a, cmp_key, new_pub;

	assign sp        = is_private(in_data.src_addr);
	assign dp        = is_private(in_data.dst_addr);
	assign last      = (idx_q == IDX_W'(POOL_DEPTH - 1));
	assign cmp_a     = (state_q == ST_SCAN_SRC) ? priv_q[idx_q] : pub_q[idx_q];
	assign cmp_key   = (state_q == ST_SCAN_SRC) ? src_q : dst_q;
	assign hit       = valid_q[idx_q] && (cmp_a == cmp_key);
	assign in_pool   = CMP_W'(idx_q) < CMP_W'(pool_count_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign can_alloc = slot_found_q && ent_found_q;
	assign new_pub   = pool_base_q + ADDR_W'(slot_q);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (dp)
						state_d = ST_DONE;
					else if (sp)
						state_d = ST_SCAN_SRC;
					else
						state_d = ST_SCAN_DST;
				end
			end
			ST_SCAN_SRC: begin
				if (hit)
					state_d = ST_DONE;
				else if (last)
					state_d = ST_ALLOC;
			end
			ST_SCAN_DST: begin
				if (hit || last)
					state_d = ST_DONE;
			end
			ST_ALLOC: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			idx_q        <= '0;
			slot_found_q <= 1'b0;
			ent_found_q  <= 1'b0;
			valid_q      <= '0;
			busy_q       <= '0;
			out_valid_q  <= 1'b0;
			pool_base_q  <= '0;
			pool_count_q <= POOL_COUNT_RST;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_POOL_BASE:  pool_base_q  <= cfg_data;
					REG_POOL_COUNT: pool_count_q <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					idx_q        <= '0;
					slot_found_q <= 1'b0;
					ent_found_q  <= 1'b0;
				end
				ST_SCAN_SRC: begin
					idx_q <= idx_q + 1'b1;
					if (!valid_q[idx_q] && !ent_found_q)
						ent_found_q <= 1'b1;
					if (!busy_q[idx_q] && !slot_found_q && in_pool)
						slot_found_q <= 1'b1;
				end
				ST_SCAN_DST: idx_q <= idx_q + 1'b1;
				ST_ALLOC: begin
					if (can_alloc) begin
						busy_q[slot_q] <= 1'b1;
						valid_q[ent_q] <= 1'b1;
					end
				end
				default: ;
			endcase
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					src_q              <= in_data.src_addr;
					dst_q              <= in_data.dst_addr;
					res_q.new_src_addr <= in_data.src_addr;
					res_q.new_dst_addr <= in_data.dst_addr;
					if (sp && dp)
						res_q.verdict <= V_PASS;
					else if (dp)
						res_q.verdict <= V_BLOCK;
					else if (sp)
						res_q.verdict <= V_EXHAUST;
					else
						res_q.verdict <= V_MISS;
				end
			end
			ST_SCAN_SRC: begin
				if (hit) begin
					res_q.new_src_addr <= pub_q[idx_q];
					res_q.verdict      <= V_XLAT;
				end
				if (!valid_q[idx_q] && !ent_found_q)
					ent_q <= idx_q;
				if (!busy_q[idx_q] && !slot_found_q && in_pool)
					slot_q <= idx_q;
			end
			ST_SCAN_DST: begin
				if (hit) begin
					res_q.new_dst_addr <= priv_q[idx_q];
					res_q.verdict      <= V_XLAT;
				end
			end
			ST_ALLOC: begin
				if (can_alloc) begin
					priv_q[ent_q]      <= src_q;
					pub_q[ent_q]       <= new_pub;
					res_q.new_src_addr <= new_pub;
					res_q.verdict      <= V_XLAT;
				end
			end
			ST_DONE: begin
				if (out_free)
					out_q <= res_q;
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/nat_checker.sv
// ----------------------------------------------------------------------------
// NAT address translator checker
// Port-level checks on the translator, attached by bind.
// ----------------------------------------------------------------------------
`include "nat_address_translator_defines.svh"

module nat_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input logic          out_valid,
	input logic          out_stall,
	input nat_pkg::out_t out_data
);
	import nat_pkg::*;

	// stalled result holds
	`NAT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed while stalled")

	// one packet at a time: busy straight after a transfer in
	`NAT_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "input taken while busy")

	// a blocked packet always came from a public source
	`NAT_ASSERT(a_block_public, out_valid && out_data.verdict == V_BLOCK |-> !is_private(out_data.new_src_addr), "blocked packet has private source")

	`NAT_ASSERT_RST(a_reset_idle, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind nat_address_translator nat_checker u_nat_checker (.*);
